// File: sv/lpm_route_table_dv_update_defines.svh
// ---------------------------------------------------------------------------
// lpm route table assertion macros
// shared property wrappers for the route table checker
// ---------------------------------------------------------------------------
`ifndef LPM_ROUTE_TABLE_DV_UPDATE_DEFINES_SVH
`define LPM_ROUTE_TABLE_DV_UPDATE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define LPMRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpm route table check failed");

// next-cycle implication, reset masks the check
`define LPMRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpm route table check failed");

`endif

// File: sv/lpmrt_pkg.sv
// ---------------------------------------------------------------------------
// lpm route table package
// request, response and table entry types, status and function codes
// ---------------------------------------------------------------------------
package lpmrt_pkg;

    // one request as presented on the input channel
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [5:0]  mask_len;
        logic [7:0]  hop_distance;
        logic [3:0]  ingress_port;
    } t_route_req;

    // one response as presented on the output channel
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] out_port;
        logic [5:0] route_total;
    } t_route_rsp;

    // one stored route
    typedef struct packed {
        logic [31:0] network;
        logic [31:0] mask;
        logic [7:0]  distance;
        logic [3:0]  port;
    } t_route_entry;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // request kinds
    localparam logic [1:0] FUNC_FORWARD = 2'd0;
    localparam logic [1:0] FUNC_ADVERT  = 2'd1;
    localparam logic [1:0] FUNC_STATIC  = 2'd2;

    // response status codes
    localparam logic [2:0] ST_FORWARDED = 3'd0;
    localparam logic [2:0] ST_NO_ROUTE  = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_INSERTED  = 3'd3;
    localparam logic [2:0] ST_UNCHANGED = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [4:0] PORT_COUNT_RST  = 5'd4;
    localparam logic [5:0] MASK_LEN_MAX    = 6'd32;
    localparam logic [7:0] DISTANCE_MAX    = 8'hFF;

    // prefix length to mask; a length of zero gives an empty mask
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// File: sv/lpmrt_ram.sv
// ---------------------------------------------------------------------------
// lpm route table ram
// simple dual port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module lpmrt_ram #(
    parameter int WIDTH = 76,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lpm_route_table_dv_update.sv
// ---------------------------------------------------------------------------
// lpm route table with distance vector update
// longest prefix lookup, distance vector advert and static route load over a
// route table held in one ram and walked by a shared compare unit
// ---------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  in       input      valid / stall    t_route_req (one request)
//  out      output     valid / stall    t_route_rsp (one response per request)
//  cfg      input      valid / ready    port_count, 5 bits
//
//  lookup and advert: one ram read per entry in the table, a compare of each
//  entry read, a step to leave the walk and one to decide and write back; the
//  decide step waits while the output register is held by a stall.
//  static load and unused codes: no table walk, straight to the decide step.
//  a request is taken only while the sequencer is idle; a finished response
//  waits in the output register and a new request may be taken meanwhile.
//  reset empties the table (count to zero) and sets port_count to 4; no
//  clearing pass, entries at or above the count are never read.
// ---------------------------------------------------------------------------
module lpm_route_table_dv_update #(
    parameter int ROUTE_ENTRIES = 32,
    parameter int PORT_LIMIT    = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  lpmrt_pkg::t_route_req  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output lpmrt_pkg::t_route_rsp  o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [4:0]             i_cfg_data
);

    import lpmrt_pkg::*;

    localparam int IDX_W  = $clog2(ROUTE_ENTRIES);
    localparam int CNT_W  = $clog2(ROUTE_ENTRIES + 1);
    localparam int PLIM_W = $clog2(PORT_LIMIT + 1);
    localparam int LIM_W  = (PLIM_W > 5) ? PLIM_W : 5;
    localparam int ENT_W  = $bits(t_route_entry);

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ROUTE_ENTRIES);
    localparam logic [LIM_W-1:0] LIM_PORTS = LIM_W'(PORT_LIMIT);

    // sequencer and item registers
    t_state           r_state, n_state;
    t_route_req       r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_valid;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [4:0]       r_port_count;

    // match tracking
    logic             r_hit, n_hit;
    logic [31:0]      r_best_mask, n_best_mask;
    logic [3:0]       r_best_port, n_best_port;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [7:0]       r_hit_dist, n_hit_dist;

    // output register
    logic             r_out_valid;
    t_route_rsp       r_out_data;

    // ram ports
    logic             rd_issue;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_route_entry     ram_wdata;
    t_route_entry     ram_rdata;

    // decision signals
    logic             in_accept;
    logic             out_free;
    logic             finish;
    logic [LIM_W-1:0] port_lim;
    logic [7:0]       adv_dist;
    logic [31:0]      static_mask;
    logic             can_append;
    logic             dec_we;
    logic [IDX_W-1:0] dec_waddr;
    t_route_entry     dec_entry;
    logic [2:0]       dec_status;
    logic [3:0]       dec_port;
    logic             dec_append;
    logic             lk_match;
    logic             adv_match;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rd_issue  = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign finish    = (r_state == S_DONE) && out_free;

    // route table storage
    lpmrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ROUTE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.func == FUNC_FORWARD || i_in_data.func == FUNC_ADVERT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (!rd_issue && !r_cmp_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  o_in_stall = 1'b1;
            S_DONE:  ram_we     = dec_we && out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign ram_waddr   = dec_waddr;
    assign ram_wdata   = dec_entry;
    assign o_cfg_ready = 1'b1;

    // shared compare unit on the entry just read
    always_comb begin
        lk_match  = ((r_req.dest_addr & ram_rdata.mask) == ram_rdata.network)
                    && (!r_hit || ram_rdata.mask > r_best_mask);
        adv_match = (ram_rdata.network == r_req.dest_addr)
                    && (ram_rdata.mask == r_req.net_mask) && !r_hit;

        n_hit       = r_hit;
        n_best_mask = r_best_mask;
        n_best_port = r_best_port;
        n_hit_idx   = r_hit_idx;
        n_hit_dist  = r_hit_dist;
        if (r_cmp_valid) begin
            if (r_req.func == FUNC_FORWARD) begin
                if (lk_match) begin
                    n_hit       = 1'b1;
                    n_best_mask = ram_rdata.mask;
                    n_best_port = ram_rdata.port;
                end
            end else if (adv_match) begin
                n_hit      = 1'b1;
                n_hit_idx  = r_cmp_idx;
                n_hit_dist = ram_rdata.distance;
            end
        end
    end

    // decision at the end of the walk
    always_comb begin
        port_lim    = (LIM_W'(r_port_count) < LIM_PORTS) ? LIM_W'(r_port_count) : LIM_PORTS;
        adv_dist    = (r_req.hop_distance == DISTANCE_MAX) ? DISTANCE_MAX
                      : r_req.hop_distance + 8'd1;
        static_mask = prefix_mask(r_req.mask_len);
        can_append  = r_count < CNT_FULL;

        dec_we     = 1'b0;
        dec_append = 1'b0;
        dec_waddr  = r_count[IDX_W-1:0];
        dec_status = ST_UNCHANGED;
        dec_port   = 4'd0;
        dec_entry  = '{network:  r_req.dest_addr,
                       mask:     r_req.net_mask,
                       distance: adv_dist,
                       port:     r_req.ingress_port};

        unique case (r_req.func)
            FUNC_FORWARD: begin
                if (r_hit && LIM_W'(r_best_port) < port_lim) begin
                    dec_status = ST_FORWARDED;
                    dec_port   = r_best_port;
                end else begin
                    dec_status = ST_NO_ROUTE;
                end
            end
            FUNC_ADVERT: begin
                if (r_hit) begin
                    if (adv_dist < r_hit_dist) begin
                        dec_we     = 1'b1;
                        dec_waddr  = r_hit_idx;
                        dec_status = ST_UPDATED;
                    end
                end else if (can_append) begin
                    dec_we     = 1'b1;
                    dec_append = 1'b1;
                    dec_status = ST_INSERTED;
                end else begin
                    dec_status = ST_FULL;
                end
            end
            FUNC_STATIC: begin
                dec_entry = '{network:  r_req.dest_addr & static_mask,
                              mask:     static_mask,
                              distance: r_req.hop_distance,
                              port:     r_req.ingress_port};
                if (r_req.mask_len <= MASK_LEN_MAX) begin
                    if (can_append) begin
                        dec_we     = 1'b1;
                        dec_append = 1'b1;
                        dec_status = ST_INSERTED;
                    end else begin
                        dec_status = ST_FULL;
                    end
                end
            end
            default: dec_status = ST_UNCHANGED;
        endcase

        n_count = dec_append ? r_count + CNT_W'(1) : r_count;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cmp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_port_count <= PORT_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= rd_issue;
            if (finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_port_count <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= r_rd_idx[IDX_W-1:0];
        r_best_mask <= n_best_mask;
        r_best_port <= n_best_port;
        r_hit_idx   <= n_hit_idx;
        r_hit_dist  <= n_hit_dist;
        if (in_accept) begin
            r_req    <= i_in_data;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_hit <= n_hit;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
        if (finish) begin
            r_out_data <= '{status:      dec_status,
                            out_port:    dec_port,
                            route_total: 6'(n_count)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/lpmrt_checker.sv
// ---------------------------------------------------------------------------
// lpm route table checker
// port level assertions, bound onto the route table top level
// ---------------------------------------------------------------------------
`include "lpm_route_table_dv_update_defines.svh"

module lpmrt_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input lpmrt_pkg::t_route_req i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input lpmrt_pkg::t_route_rsp o_out_data
);

    import lpmrt_pkg::*;

    // a stalled response stays offered
    `LPMRT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled response keeps its payload
    `LPMRT_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // one request at a time: input stalls straight after a request is taken
    `LPMRT_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_rst_n && i_in_valid && !o_in_stall, o_in_stall)

    // a port is only reported on a forwarded lookup
    `LPMRT_ASSERT_IMP(a_port_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_FORWARDED, o_out_data.out_port == 4'd0)

endmodule

bind lpm_route_table_dv_update lpmrt_checker u_lpmrt_checker (.*);

// File: sim/lpmrt_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lpm route table scoreboard
// keeps a shadow route table and port count in step with the block, works out
// the response to every accepted request and checks responses in order
// ---------------------------------------------------------------------------
package lpmrt_tb_pkg;
    import lpmrt_pkg::*;

    localparam int         TABLE_DEPTH = 32;
    localparam int         PORT_CAP    = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // netmask from a prefix length of 0 to 32
    function automatic logic [31:0] netmask_of(input int len);
        if (len == 0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    class route_table_scoreboard;
        logic [31:0] net_tab  [TABLE_DEPTH];
        logic [31:0] mask_tab [TABLE_DEPTH];
        logic [7:0]  dist_tab [TABLE_DEPTH];
        logic [3:0]  port_tab [TABLE_DEPTH];
        int          used;
        logic [4:0]  ports_present;
        t_route_rsp  awaited[$];
        int          fail_count;
        int          rsp_index;

        function new();
            used          = 0;
            ports_present = PORT_COUNT_RST;
            fail_count    = 0;
            rsp_index     = 0;
        endfunction

        function void set_port_count(input logic [4:0] value);
            ports_present = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // entries are only ever appended at the end
        function bit append_route(input logic [31:0] net, input logic [31:0] mask,
                                  input logic [7:0] hops, input logic [3:0] port);
            if (used >= TABLE_DEPTH) return 1'b0;
            net_tab[used]  = net;
            mask_tab[used] = mask;
            dist_tab[used] = hops;
            port_tab[used] = port;
            used++;
            return 1'b1;
        endfunction

        // response to one request, table updated as a side effect
        function t_route_rsp predict_response(input t_route_req req);
            t_route_rsp  rsp;
            logic [31:0] best_mask;
            logic [31:0] mask;
            logic [7:0]  adv_hops;
            int          best;
            int          limit;
            bit          hit;
            bit          known;
            rsp = '0;
            case (req.func)
                FUNC_FORWARD: begin
                    // longest mask wins, earliest entry on a tie
                    hit       = 1'b0;
                    best      = 0;
                    best_mask = '0;
                    for (int i = 0; i < used; i++) begin
                        if ((req.dest_addr & mask_tab[i]) == net_tab[i] &&
                            (!hit || mask_tab[i] > best_mask)) begin
                            hit       = 1'b1;
                            best      = i;
                            best_mask = mask_tab[i];
                        end
                    end
                    limit = (ports_present < PORT_CAP) ? ports_present : PORT_CAP;
                    if (hit && port_tab[best] < limit) begin
                        rsp.status   = ST_FORWARDED;
                        rsp.out_port = port_tab[best];
                    end else begin
                        rsp.status = ST_NO_ROUTE;
                    end
                end
                FUNC_ADVERT: begin
                    // one hop further, saturating
                    adv_hops = (req.hop_distance == DISTANCE_MAX) ? DISTANCE_MAX
                                                                  : req.hop_distance + 8'd1;
                    known    = 1'b0;
                    for (int i = 0; i < used; i++) begin
                        if (!known && net_tab[i] == req.dest_addr &&
                            mask_tab[i] == req.net_mask) begin
                            known = 1'b1;
                            if (adv_hops < dist_tab[i]) begin
                                dist_tab[i] = adv_hops;
                                port_tab[i] = req.ingress_port;
                                rsp.status  = ST_UPDATED;
                            end else begin
                                rsp.status = ST_UNCHANGED;
                            end
                        end
                    end
                    if (!known) begin
                        rsp.status = append_route(req.dest_addr, req.net_mask, adv_hops,
                                                  req.ingress_port) ? ST_INSERTED : ST_FULL;
                    end
                end
                FUNC_STATIC: begin
                    if (req.mask_len > MASK_LEN_MAX) begin
                        rsp.status = ST_UNCHANGED;
                    end else begin
                        mask       = netmask_of(int'(req.mask_len));
                        rsp.status = append_route(req.dest_addr & mask, mask,
                                                  req.hop_distance, req.ingress_port)
                                     ? ST_INSERTED : ST_FULL;
                    end
                end
                default: begin
                    rsp.status = ST_UNCHANGED;
                end
            endcase
            rsp.route_total = 6'(used);
            return rsp;
        endfunction

        function void note_request(input t_route_req req);
            awaited.push_back(predict_response(req));
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            fail_count++;
        endtask

        // compare one response against the oldest outstanding expectation
        task check_response(input t_route_rsp got);
            t_route_rsp want;
            rsp_index++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("response %0d arrived with none awaited",
                                          rsp_index));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                          rsp_index, got.status, want.status));
            if (got.out_port !== want.out_port)
                report_mismatch($sformatf("response %0d out_port %0d, expected %0d",
                                          rsp_index, got.out_port, want.out_port));
            if (got.route_total !== want.route_total)
                report_mismatch($sformatf("response %0d route_total %0d, expected %0d",
                                          rsp_index, got.route_total, want.route_total));
        endtask
    endclass

endpackage

// File: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lpm route table testbench
// directed lookups, adverts and static loads over an empty then filling table,
// then random phases at several port counts with random idling on both
// channels and one long output hold-off; every response checked in order
// ---------------------------------------------------------------------------
module tb;
    import lpmrt_pkg::*;
    import lpmrt_tb_pkg::*;

    localparam int RUN_LIMIT   = 800000;
    localparam int DRAIN_GAP   = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_ITEMS = 290;
    localparam int POOL_MAX    = 64;
    localparam logic [4:0] PHASE_PORTS [7] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd2, 5'd4};

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_route_req in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_route_rsp out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = PORT_COUNT_RST;

    route_table_scoreboard sb;

    bit          quiet     = 1'b0;
    bit          hold_go   = 1'b0;
    logic        hold_long = 1'b0;
    int          stall_left = 0;
    int          cycles    = 0;
    logic [31:0] pool_net[$];
    logic [31:0] pool_mask[$];
    t_route_req  directed[$];

    lpm_route_table_dv_update DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: random hold-off after each response, plus the long hold
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                sb.check_response(out_data);
                stall_left = quiet ? 0 : $urandom_range(0, 12);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= hold_long || (stall_left > 0);
        end
    end

    // long hold-off so the block fills up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    function automatic t_route_req make_req(input logic [1:0] func, input logic [31:0] addr,
                                            input logic [31:0] mask, input logic [5:0] len,
                                            input logic [7:0] hop, input logic [3:0] port);
        t_route_req req;
        req.func         = func;
        req.dest_addr    = addr;
        req.net_mask     = mask;
        req.mask_len     = len;
        req.hop_distance = hop;
        req.ingress_port = port;
        return req;
    endfunction

    function automatic void remember(input logic [31:0] net, input logic [31:0] mask);
        if (pool_net.size() < POOL_MAX) begin
            pool_net.push_back(net);
            pool_mask.push_back(mask);
        end
    endfunction

    // mostly well-formed traffic over known networks, a little fresh and noisy
    function automatic t_route_req random_request();
        t_route_req  req;
        logic [31:0] mask;
        int          pick;
        int          k;
        int          len;
        req.func         = FUNC_FORWARD;
        req.dest_addr    = $urandom;
        req.net_mask     = $urandom;
        req.mask_len     = 6'($urandom_range(0, 63));
        req.hop_distance = 8'($urandom_range(0, 255));
        req.ingress_port = 4'($urandom_range(0, 15));
        k    = (pool_net.size() > 0) ? $urandom_range(0, pool_net.size() - 1) : 0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // lookup, usually inside a known network
            if (pool_net.size() > 0 && $urandom_range(0, 9) < 7)
                req.dest_addr = pool_net[k] | ($urandom & ~pool_mask[k]);
        end else if (pick < 88) begin
            req.func = FUNC_ADVERT;
            if (pool_net.size() > 0 && $urandom_range(0, 99) >= 6) begin
                req.dest_addr = pool_net[k];
                req.net_mask  = pool_mask[k];
                case ($urandom_range(0, 3))
                    0:       req.hop_distance = DISTANCE_MAX;
                    1, 2:    req.hop_distance = 8'($urandom_range(0, 20));
                    default: req.hop_distance = 8'($urandom_range(0, 255));
                endcase
            end else begin
                // fresh network, sometimes with host bits left set
                len          = $urandom_range(0, 32);
                mask         = netmask_of(len);
                req.net_mask = mask;
                if ($urandom_range(0, 3) != 0) req.dest_addr = req.dest_addr & mask;
                remember(req.dest_addr, mask);
            end
        end else if (pick < 92) begin
            req.func = FUNC_STATIC;
            if ($urandom_range(0, 9) == 0) begin
                req.mask_len = 6'($urandom_range(33, 63));
            end else if (pool_net.size() > 0 && $urandom_range(0, 9) < 3) begin
                req.mask_len  = 6'($countones(pool_mask[k]));
                req.dest_addr = pool_net[k] | ($urandom & ~pool_mask[k]);
            end else begin
                len          = $urandom_range(0, 32);
                req.mask_len = 6'(len);
                remember(req.dest_addr & netmask_of(len), netmask_of(len));
            end
        end else begin
            req.func = FUNC_UNUSED;
        end
        return req;
    endfunction

    // present one request and hold it until taken
    task automatic send_request(input t_route_req req);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_port_count(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.set_port_count(value);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_route_req req;
        int         counted;
        sb = new();

        // reset
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        write_port_count(PORT_COUNT_RST);

        // directed: empty table, edge fields, ignored loads, adverts, tie, lookups
        directed.push_back(make_req(FUNC_FORWARD, 32'hC0A8_0101, 32'hFFFF_FFFF, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 8'd255,
                                    4'd15));
        directed.push_back(make_req(FUNC_STATIC, 32'hFFFF_FFFF, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_STATIC, 32'h0A0B_0C0D, 32'h0, 6'd32, 8'd255, 4'd15));
        directed.push_back(make_req(FUNC_STATIC, 32'h0102_0304, 32'h0, 6'd33, 8'd7, 4'd1));
        directed.push_back(make_req(FUNC_STATIC, 32'h0102_0304, 32'h0, 6'd63, 8'd7, 4'd1));
        directed.push_back(make_req(FUNC_STATIC, 32'hC0A8_0155, 32'h0, 6'd24, 8'd10, 4'd3));
        directed.push_back(make_req(FUNC_ADVERT, 32'hC0A8_0100, 32'hFFFF_FF00, 6'd0, 8'd0, 4'd2));
        directed.push_back(make_req(FUNC_ADVERT, 32'hC0A8_0100, 32'hFFFF_FF00, 6'd0, 8'd254,
                                    4'd1));
        directed.push_back(make_req(FUNC_ADVERT, 32'h0A00_0000, 32'hFF00_0000, 6'd0, 8'd255,
                                    4'd1));
        directed.push_back(make_req(FUNC_ADVERT, 32'h0A00_0000, 32'hFF00_0000, 6'd0, 8'd254,
                                    4'd3));
        directed.push_back(make_req(FUNC_ADVERT, 32'h0A00_0000, 32'hFF00_0000, 6'd0, 8'd253,
                                    4'd1));
        directed.push_back(make_req(FUNC_ADVERT, 32'h0A00_0001, 32'hFF00_0000, 6'd0, 8'd5, 4'd3));
        directed.push_back(make_req(FUNC_ADVERT, 32'h0, 32'h0, 6'd0, 8'd0, 4'd2));
        directed.push_back(make_req(FUNC_STATIC, 32'hC0A8_0199, 32'h0, 6'd24, 8'd1, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'hC0A8_0177, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'h0A0B_0C0D, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'h0A12_3456, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'h0A00_0001, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'h0, 32'h0, 6'd0, 8'd0, 4'd0));
        directed.push_back(make_req(FUNC_FORWARD, 32'hFFFF_FFFF, 32'h0, 6'd0, 8'd0, 4'd0));
        foreach (directed[i]) send_request(directed[i]);
        in_valid <= 1'b0;
        wait_drained();

        // all ports present: the host route on port 15 now forwards
        write_port_count(5'd16);
        send_request(make_req(FUNC_FORWARD, 32'h0A0B_0C0D, 32'h0, 6'd0, 8'd0, 4'd0));
        send_request(make_req(FUNC_FORWARD, 32'hC0A8_01FE, 32'h0, 6'd0, 8'd0, 4'd0));
        in_valid <= 1'b0;
        wait_drained();

        remember(32'hC0A8_0100, 32'hFFFF_FF00);
        remember(32'h0A00_0000, 32'hFF00_0000);
        remember(32'h0A0B_0C0D, 32'hFFFF_FFFF);
        remember(32'h0, 32'h0);

        // random phases at several port counts
        for (int ph = 0; ph < 7; ph++) begin
            quiet = (ph % 3 == 2);
            write_port_count((ph == 4) ? 5'($urandom_range(1, 16)) : PHASE_PORTS[ph]);
            if (ph == 1) hold_go = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req = random_request();
                send_request(req);
                if (req.func != FUNC_UNUSED &&
                    !(req.func == FUNC_STATIC && req.mask_len > MASK_LEN_MAX))
                    counted++;
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
